### rtl/url_list_and_term_filter_assert.svh
// assertion macros for the url filter block
`ifndef URL_LIST_AND_TERM_FILTER_ASSERT_SVH
`define URL_LIST_AND_TERM_FILTER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define UF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define UF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/url_filt_pkg.sv
// ----------------------------------------------------------------------------
// url_filt_pkg
// Request kinds, verdict reasons and character codes of the url filter.
// ----------------------------------------------------------------------------
package url_filt_pkg;

  // request kinds carried by req_type
  localparam logic [1:0] REQ_ALLOW = 2'd0;
  localparam logic [1:0] REQ_BLOCK = 2'd1;
  localparam logic [1:0] REQ_TERM  = 2'd2;
  localparam logic [1:0] REQ_URL   = 2'd3;

  // table slots inside a memory row
  localparam int unsigned NUM_TBL = 3;

  // verdict reasons
  localparam logic [1:0] RSN_ALLOW   = 2'd0;
  localparam logic [1:0] RSN_BLOCK   = 2'd1;
  localparam logic [1:0] RSN_TERM    = 2'd2;
  localparam logic [1:0] RSN_NO_RULE = 2'd3;

  // characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

endpackage

### rtl/url_list_and_term_filter.sv
// a load item is taken while idle; a url item starts a walk over the entry
// memory, one row a cycle, and holds the input stalled until the walk is done
// throughput: one item at a time, next item accepted when the previous is done
// the result register lets the next item in while a verdict waits to be taken
// reset clears valid bits, match flags, window and control; memories are not
// cleared, an entry is ignored until its last character is loaded
// ----------------------------------------------------------------------------
// url_list_and_term_filter
// Judges a url that arrives one character per item against allow prefixes,
// block prefixes and banned terms loaded beforehand.
// ----------------------------------------------------------------------------
module url_list_and_term_filter #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned TERM_LEN = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] req_type_i,
  input  logic [3:0] entry_index_i,
  input  logic [7:0] char_value_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       verdict_o,
  output logic [1:0] reason_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(TERM_LEN);
  localparam int unsigned LW = $clog2(TERM_LEN + 1);
  localparam int unsigned PW = $clog2(TERM_LEN + 2);
  localparam int unsigned NT = url_filt_pkg::NUM_TBL;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN
  } state_e;

  state_e state_q;

  logic                           in_acc;
  logic                           load_acc;
  logic                           url_acc;
  logic                           in_range;

  logic [PW-1:0]                  load_pos_q;
  logic [PW-1:0]                  load_cnt;
  logic [PW-1:0]                  url_pos_q;
  logic [PW-1:0]                  url_cnt;
  logic [PW-1:0]                  pos_q;
  logic [PW-1:0]                  count_q;
  logic [7:0]                     char_q;
  logic                           last_q;
  logic [7:0]                     mapped_char;
  logic [TERM_LEN-1:0][7:0]       win_q;

  logic [ENTRIES-1:0][NT-1:0]     valid_q;
  logic [ENTRIES-1:0]             allow_match_q;
  logic [ENTRIES-1:0]             block_match_q;
  logic                           allow_hit_q;
  logic                           block_hit_q;
  logic                           term_seen_q;

  logic [IW:0]                    walk_cnt_q;
  logic                           issue_done_q;
  logic                           p_valid_q;
  logic [IW-1:0]                  p_idx_q;

  logic [NT-1:0][TERM_LEN-1:0][7:0] rd_chars;
  logic [NT-1:0][LW-1:0]            rd_lens;

  logic                           out_valid_q;
  logic                           verdict_q;
  logic [1:0]                     reason_q;

  // per-entry results of the walk
  logic [PW-1:0]                  len_a;
  logic [PW-1:0]                  len_b;
  logic [PW-1:0]                  len_t;
  logic [7:0]                     byte_a;
  logic [7:0]                     byte_b;
  logic                           flag_a;
  logic                           flag_b;
  logic                           hit_a;
  logic                           hit_b;
  logic [PW-1:0]                  shamt;
  logic [TERM_LEN-1:0][7:0]       win_shift;
  logic                           term_eq;
  logic                           hit_t;
  logic                           out_free;

  // handshake
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign url_acc    = in_acc && (req_type_i == url_filt_pkg::REQ_URL);
  assign in_range   = (32'(entry_index_i) < ENTRIES);
  assign load_acc   = in_acc && (req_type_i != url_filt_pkg::REQ_URL) && in_range;
  assign out_free   = !out_valid_q || !out_stall_i;

  // load position and url position counts, saturating
  assign load_cnt = (load_pos_q >= PW'(TERM_LEN)) ? PW'(TERM_LEN) : load_pos_q + PW'(1);
  assign url_cnt  = (url_pos_q >= PW'(TERM_LEN + 1)) ? PW'(TERM_LEN + 1)
                                                     : url_pos_q + PW'(1);
  assign mapped_char = (char_value_i == url_filt_pkg::CH_PLUS ||
                        char_value_i == url_filt_pkg::CH_MINUS) ?
                       url_filt_pkg::CH_SPACE : char_value_i;

  // entry memories
  url_filt_store #(
    .ENTRIES  (ENTRIES),
    .TERM_LEN (TERM_LEN)
  ) u_store (
    .clk_i        (clk_i),
    .wr_en_i      (load_acc),
    .wr_row_i     (IW'(entry_index_i)),
    .wr_tbl_i     (req_type_i),
    .wr_char_en_i (load_pos_q < PW'(TERM_LEN)),
    .wr_pos_i     (load_pos_q[CW-1:0]),
    .wr_char_i    (char_value_i),
    .wr_len_en_i  (last_i),
    .wr_len_i     (LW'(load_cnt)),
    .rd_row_i     (walk_cnt_q[IW-1:0]),
    .rd_chars_o   (rd_chars),
    .rd_lens_o    (rd_lens)
  );

  // prefix checks for the entry read back
  always_comb begin
    len_a  = valid_q[p_idx_q][url_filt_pkg::REQ_ALLOW] ?
             PW'(rd_lens[url_filt_pkg::REQ_ALLOW]) : '0;
    len_b  = valid_q[p_idx_q][url_filt_pkg::REQ_BLOCK] ?
             PW'(rd_lens[url_filt_pkg::REQ_BLOCK]) : '0;
    byte_a = rd_chars[url_filt_pkg::REQ_ALLOW][pos_q[CW-1:0]];
    byte_b = rd_chars[url_filt_pkg::REQ_BLOCK][pos_q[CW-1:0]];
    flag_a = allow_match_q[p_idx_q] && !((pos_q < len_a) && (byte_a != char_q));
    flag_b = block_match_q[p_idx_q] && !((pos_q < len_b) && (byte_b != char_q));
    hit_a  = valid_q[p_idx_q][url_filt_pkg::REQ_ALLOW] && flag_a && (count_q >= len_a);
    hit_b  = valid_q[p_idx_q][url_filt_pkg::REQ_BLOCK] && flag_b && (count_q >= len_b);
  end

  // banned term check: align the window tail with the term start
  always_comb begin
    len_t     = PW'(rd_lens[url_filt_pkg::REQ_TERM]);
    shamt     = PW'(TERM_LEN) - len_t;
    win_shift = win_q >> {shamt, 3'b000};
    term_eq   = 1'b1;
    for (int k = 0; k < TERM_LEN; k++) begin
      if ((PW'(k) < len_t) && (win_shift[k] != rd_chars[url_filt_pkg::REQ_TERM][k])) begin
        term_eq = 1'b0;
      end
    end
    hit_t = valid_q[p_idx_q][url_filt_pkg::REQ_TERM] && (len_t != '0) &&
            (len_t <= PW'(TERM_LEN)) && (count_q >= len_t) && term_eq;
  end

  // control, url state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      load_pos_q    <= '0;
      url_pos_q     <= '0;
      pos_q         <= '0;
      count_q       <= '0;
      char_q        <= '0;
      last_q        <= 1'b0;
      win_q         <= {TERM_LEN{url_filt_pkg::CH_SPACE}};
      valid_q       <= '0;
      allow_match_q <= '1;
      block_match_q <= '1;
      allow_hit_q   <= 1'b0;
      block_hit_q   <= 1'b0;
      term_seen_q   <= 1'b0;
      walk_cnt_q    <= '0;
      issue_done_q  <= 1'b0;
      p_valid_q     <= 1'b0;
      p_idx_q       <= '0;
      out_valid_q   <= 1'b0;
      verdict_q     <= 1'b0;
      reason_q      <= url_filt_pkg::RSN_NO_RULE;
    end else begin
      // result taken; the end of a url sets it again below
      if (!out_stall_i && !(state_q == ST_FIN && last_q)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          // load item: the memory write happens in the store
          if (load_acc) begin
            if (last_i) begin
              valid_q[IW'(entry_index_i)][req_type_i] <= 1'b1;
              load_pos_q <= '0;
            end else begin
              load_pos_q <= load_cnt;
            end
          end
          // url item: shift the window and start the walk
          if (url_acc) begin
            pos_q        <= url_pos_q;
            count_q      <= url_cnt;
            url_pos_q    <= url_cnt;
            char_q       <= char_value_i;
            last_q       <= last_i;
            win_q        <= {mapped_char, win_q[TERM_LEN-1:1]};
            allow_hit_q  <= 1'b0;
            block_hit_q  <= 1'b0;
            walk_cnt_q   <= '0;
            issue_done_q <= 1'b0;
            state_q      <= ST_WALK;
          end
        end
        ST_WALK: begin
          // issue one row read a cycle
          p_valid_q <= !issue_done_q;
          p_idx_q   <= walk_cnt_q[IW-1:0];
          if (!issue_done_q) begin
            if (walk_cnt_q == (IW+1)'(ENTRIES - 1)) begin
              issue_done_q <= 1'b1;
            end else begin
              walk_cnt_q <= walk_cnt_q + (IW+1)'(1);
            end
          end
          // update the flags of the row that came back
          if (p_valid_q) begin
            allow_match_q[p_idx_q] <= flag_a;
            block_match_q[p_idx_q] <= flag_b;
            if (hit_a) allow_hit_q <= 1'b1;
            if (hit_b) block_hit_q <= 1'b1;
            if (hit_t) term_seen_q <= 1'b1;
            if (p_idx_q == IW'(ENTRIES - 1)) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            out_valid_q <= 1'b1;
            if (allow_hit_q) begin
              verdict_q <= 1'b1;
              reason_q  <= url_filt_pkg::RSN_ALLOW;
            end else if (block_hit_q) begin
              verdict_q <= 1'b0;
              reason_q  <= url_filt_pkg::RSN_BLOCK;
            end else if (term_seen_q) begin
              verdict_q <= 1'b0;
              reason_q  <= url_filt_pkg::RSN_TERM;
            end else begin
              verdict_q <= 1'b1;
              reason_q  <= url_filt_pkg::RSN_NO_RULE;
            end
            // back to the start of a url
            url_pos_q     <= '0;
            win_q         <= {TERM_LEN{url_filt_pkg::CH_SPACE}};
            allow_match_q <= '1;
            block_match_q <= '1;
            term_seen_q   <= 1'b0;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;
  assign reason_o    = reason_q;

  // checks
  `include "url_list_and_term_filter_assert.svh"

  `UF_ASSERT_NOW(a_rose_from_fin, $rose(out_valid_q), $past(state_q == ST_FIN), "result without end of url")
  `UF_ASSERT_NOW(a_pipe_in_walk, p_valid_q, state_q == ST_WALK, "row processed outside walk")
  `UF_ASSERT_NEXT(a_url_starts_walk, url_acc, state_q == ST_WALK, "url item did not start walk")
  `UF_ASSERT_NOW(a_allow_forwards, out_valid_q && reason_q == url_filt_pkg::RSN_ALLOW, verdict_q, "allow hit rejected")

endmodule

### rtl/url_filt_store.sv
// ----------------------------------------------------------------------------
// url_filt_store
// Entry memories: one row per entry index holds the characters and the
// length of the allow, block and term entries. Byte writes, registered read.
// ----------------------------------------------------------------------------
module url_filt_store #(
  parameter int unsigned ENTRIES  = 16,
  parameter int unsigned TERM_LEN = 32
) (
  input  logic                                                      clk_i,
  input  logic                                                      wr_en_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]          wr_row_i,
  input  logic [1:0]                                                wr_tbl_i,
  input  logic                                                      wr_char_en_i,
  input  logic [$clog2(TERM_LEN)-1:0]                               wr_pos_i,
  input  logic [7:0]                                                wr_char_i,
  input  logic                                                      wr_len_en_i,
  input  logic [$clog2(TERM_LEN+1)-1:0]                             wr_len_i,
  input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0]          rd_row_i,
  output logic [url_filt_pkg::NUM_TBL-1:0][TERM_LEN-1:0][7:0]       rd_chars_o,
  output logic [url_filt_pkg::NUM_TBL-1:0][$clog2(TERM_LEN+1)-1:0]  rd_lens_o
);

  localparam int unsigned LW = $clog2(TERM_LEN + 1);

  logic [url_filt_pkg::NUM_TBL-1:0][TERM_LEN-1:0][7:0] chars_mem [ENTRIES];
  logic [url_filt_pkg::NUM_TBL-1:0][LW-1:0]            lens_mem  [ENTRIES];

  // byte and length writes
  always_ff @(posedge clk_i) begin
    if (wr_en_i && wr_char_en_i) begin
      chars_mem[wr_row_i][wr_tbl_i] [wr_pos_i] <= wr_char_i;
    end
    if (wr_en_i && wr_len_en_i) begin
      lens_mem[wr_row_i][wr_tbl_i] <= wr_len_i;
    end
  end

  // registered row read
  always_ff @(posedge clk_i) begin
    rd_chars_o <= chars_mem[rd_row_i];
    rd_lens_o  <= lens_mem[rd_row_i];
  end

endmodule

### test/url_list_and_term_filter_tb.sv
// ----------------------------------------------------------------------------
// url_list_and_term_filter_tb
// Loads allow, block and banned-term tables, streams urls one character per
// item, and checks each verdict against a behavioral predictor of the filter.
// ----------------------------------------------------------------------------
module url_list_and_term_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NENT = 16;
  localparam int TLEN = 32;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [1:0] req_type_i = url_filt_pkg::REQ_URL;
  logic [3:0] entry_index_i = '0;
  logic [7:0] char_value_i = '0;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       verdict_o;
  logic [1:0] reason_o;

  url_list_and_term_filter u_top (.*);

  always #4 clk_i = ~clk_i;

  typedef struct packed {
    logic       verdict;
    logic [1:0] reason;
  } verdict_t;

  // predictor state
  logic [7:0] tbl_chr [3][NENT][TLEN];
  int         tbl_len [3][NENT];
  bit         tbl_ok  [3][NENT];
  int         ld_pos;
  bit         allow_live [NENT];
  bit         block_live [NENT];
  int         url_pos;
  logic [7:0] window [TLEN];
  bit         term_hit;

  verdict_t   verdict_q[$];
  int         errors = 0;
  bit         in_quiet = 1'b0;
  bit         out_quiet = 1'b0;

  task automatic clear_url();
    for (int e = 0; e < NENT; e++) begin
      allow_live[e] = 1'b1;
      block_live[e] = 1'b1;
    end
    url_pos = 0;
    for (int k = 0; k < TLEN; k++) window[k] = url_filt_pkg::CH_SPACE;
    term_hit = 1'b0;
  endtask

  // predict the effect of one accepted item
  task automatic predict_item(logic [1:0] kind, logic [3:0] idx, logic [7:0] ch, logic lst);
    int cnt;
    bit same, ahit, bhit;
    verdict_t v;
    if (kind != url_filt_pkg::REQ_URL) begin
      if (ld_pos < TLEN) tbl_chr[kind][idx][ld_pos] = ch;
      cnt = (ld_pos + 1 > TLEN) ? TLEN : ld_pos + 1;
      if (lst) begin
        tbl_len[kind][idx] = cnt;
        tbl_ok[kind][idx] = 1'b1;
        ld_pos = 0;
      end else ld_pos = cnt;
      return;
    end
    for (int e = 0; e < NENT; e++) begin
      if (url_pos < tbl_len[0][e] && tbl_chr[0][e][url_pos] != ch) allow_live[e] = 1'b0;
      if (url_pos < tbl_len[1][e] && tbl_chr[1][e][url_pos] != ch) block_live[e] = 1'b0;
    end
    cnt = (url_pos + 1 > TLEN + 1) ? TLEN + 1 : url_pos + 1;
    url_pos = cnt;
    for (int k = 0; k < TLEN - 1; k++) window[k] = window[k+1];
    window[TLEN-1] = (ch == url_filt_pkg::CH_PLUS || ch == url_filt_pkg::CH_MINUS) ?
                     url_filt_pkg::CH_SPACE : ch;
    for (int e = 0; e < NENT; e++) begin
      int n;
      n = tbl_len[2][e];
      if (!tbl_ok[2][e] || n == 0 || cnt < n) continue;
      same = 1'b1;
      for (int k = 0; k < n; k++)
        if (tbl_chr[2][e][k] != window[TLEN-n+k]) same = 1'b0;
      if (same) term_hit = 1'b1;
    end
    if (!lst) return;
    ahit = 1'b0;
    bhit = 1'b0;
    for (int e = 0; e < NENT; e++) begin
      if (tbl_ok[0][e] && allow_live[e] && cnt >= tbl_len[0][e]) ahit = 1'b1;
      if (tbl_ok[1][e] && block_live[e] && cnt >= tbl_len[1][e]) bhit = 1'b1;
    end
    if (ahit) v = '{1'b1, url_filt_pkg::RSN_ALLOW};
    else if (bhit) v = '{1'b0, url_filt_pkg::RSN_BLOCK};
    else if (term_hit) v = '{1'b0, url_filt_pkg::RSN_TERM};
    else v = '{1'b1, url_filt_pkg::RSN_NO_RULE};
    verdict_q.push_back(v);
    clear_url();
  endtask

  // send one item, with random idle before it
  task automatic send_item(logic [1:0] kind, logic [3:0] idx, logic [7:0] ch, logic lst);
    while (!in_quiet && $urandom_range(99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= kind;
    entry_index_i <= idx;
    char_value_i  <= ch;
    last_i        <= lst;
    @(posedge clk_i iff !in_stall_o);
    predict_item(kind, idx, ch, lst);
  endtask

  // strings for loading and urls
  task automatic load_entry(logic [1:0] kind, logic [3:0] idx, string s);
    for (int i = 0; i < s.len(); i++) send_item(kind, idx, s[i], i == s.len() - 1);
  endtask

  task automatic send_url(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(url_filt_pkg::REQ_URL, 4'($urandom), s[i], i == s.len() - 1);
  endtask

  task automatic wait_drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected verdict %0d reason %0d", verdict_o, reason_o);
          errors++;
        end else begin
          verdict_t v;
          v = verdict_q.pop_front();
          if (verdict_o !== v.verdict) begin
            $error("verdict: expected %0d, got %0d", v.verdict, verdict_o);
            errors++;
          end
          if (reason_o !== v.reason) begin
            $error("reason: expected %0d, got %0d", v.reason, reason_o);
            errors++;
          end
        end
      end
      out_stall_i <= !out_quiet && ($urandom_range(99) < 35);
    end
  end

  // directed: empty tables, then one allow, one block and two term entries
  task automatic test_directed();
    send_url("a");
    load_entry(url_filt_pkg::REQ_ALLOW, 4'd0, "good.org");
    load_entry(url_filt_pkg::REQ_BLOCK, 4'd15, "bad.");
    load_entry(url_filt_pkg::REQ_TERM, 4'd3, "x y");
    load_entry(url_filt_pkg::REQ_TERM, 4'd5, string'({8'hff, 8'h80}));
    send_url("good.org/x-y");
    send_url("bad.net");
    send_url("go");
    send_url("q/x+y");
    send_url("q/x+yz");
    send_url(string'({"z", 8'hff, 8'h80}));
    wait_drain();
  endtask

  // directed: overlong entry saturates at TLEN, long urls saturate position
  task automatic test_overlong();
    string s;
    s = "";
    for (int i = 0; i < 40; i++) s = {s, "k"};
    load_entry(url_filt_pkg::REQ_BLOCK, 4'd7, s);
    send_url(s);
    send_url(s.substr(0, 30));
    in_quiet = 1'b1;
    out_quiet = 1'b1;
    send_url(s.substr(0, 32));
    in_quiet = 1'b0;
    out_quiet = 1'b0;
    wait_drain();
  endtask

  function automatic string rand_str(int n);
    string s;
    byte alpha[6] = '{"a", "b", "+", "-", " ", "c"};
    s = "";
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) s = {s, string'(byte'($urandom))};
      else s = {s, string'(alpha[$urandom_range(5)])};
    end
    return s;
  endfunction

  // random: reload tables with short entries, then stream urls
  task automatic test_random();
    string u;
    for (int round = 0; round < 6; round++) begin
      for (int j = 0; j < 4; j++) begin
        logic [1:0] kind;
        kind = 2'($urandom_range(2));
        load_entry(kind, 4'($urandom), rand_str($urandom_range(1, 4)));
      end
      if (round == 3) begin
        in_quiet = 1'b1;
        out_quiet = 1'b1;
      end
      for (int j = 0; j < 13; j++) begin
        u = rand_str($urandom_range(1, 8));
        if ($urandom_range(1) && tbl_ok[0][0]) u = {"good", u};
        send_url(u);
      end
      in_quiet = 1'b0;
      out_quiet = 1'b0;
      if (round == 2) wait_drain();
    end
  endtask

  initial begin
    ld_pos = 0;
    for (int t = 0; t < 3; t++)
      for (int e = 0; e < NENT; e++) begin
        tbl_len[t][e] = 0;
        tbl_ok[t][e] = 1'b0;
      end
    clear_url();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overlong();
    test_random();
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) $display("url_list_and_term_filter_tb: done, clean");
    else $display("url_list_and_term_filter_tb: done, errors");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("url_list_and_term_filter_tb: done, errors");
    $finish;
  end
endmodule

### url_list_and_term_filter.f
+incdir+rtl
rtl/url_filt_pkg.sv
rtl/url_filt_store.sv
rtl/url_list_and_term_filter.sv
test/url_list_and_term_filter_tb.sv
